// File: src/rhsv_pkg.sv
// rhsv_pkg: shared widths and the request record that moves down the divider chain.
// No dependencies.
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int unsigned ChanW   = 8;              // one color channel
  localparam int unsigned HueW    = 16;             // hue, fraction of a turn
  localparam int unsigned HueDivW = ChanW + 3;      // 6 * (max - min) fits here
  localparam int unsigned SatNumW = 2 * ChanW;      // (max - min) * 255
  localparam int unsigned NumCells = HueW;          // one quotient bit per cell

  // One request in flight: two restoring dividers side by side plus the value.
  typedef struct packed {
    logic               valid;
    logic [HueDivW-1:0] hue_rem;   // partial remainder, always below hue_div
    logic [HueDivW-1:0] hue_div;   // 6 * (max - min), 1 for grey
    logic [HueW-1:0]    hue_quo;
    logic [SatNumW-1:0] sat_num;   // dividend bits still to be shifted in
    logic [ChanW-1:0]   sat_rem;   // partial remainder, always below sat_div
    logic [ChanW-1:0]   sat_div;   // max, 1 for black
    logic [ChanW-1:0]   sat_quo;   // low quotient bits; the rest are zero
    logic [ChanW-1:0]   value;
  } cell_t;

endpackage

// File: src/rhsv_prep.sv
// rhsv_prep: front stage, finds max/min, picks the hue sector and loads both dividers.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [rhsv_pkg::ChanW-1:0] red_i,
  input  logic [rhsv_pkg::ChanW-1:0] green_i,
  input  logic [rhsv_pkg::ChanW-1:0] blue_i,
  output rhsv_pkg::cell_t           cell_o
);

  localparam int unsigned NumW = rhsv_pkg::HueDivW + 1;

  logic [rhsv_pkg::ChanW-1:0]   mx, mn, dif;
  logic [rhsv_pkg::HueDivW-1:0] six_d;
  logic signed [NumW-1:0]       r_s, g_s, b_s, d_s, num;
  rhsv_pkg::cell_t              cell_d, cell_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dif   = mx - mn;
    six_d = {1'b0, dif, 2'b00} + {2'b00, dif, 1'b0};

    r_s = $signed({{(NumW - rhsv_pkg::ChanW){1'b0}}, red_i});
    g_s = $signed({{(NumW - rhsv_pkg::ChanW){1'b0}}, green_i});
    b_s = $signed({{(NumW - rhsv_pkg::ChanW){1'b0}}, blue_i});
    d_s = $signed({{(NumW - rhsv_pkg::ChanW){1'b0}}, dif});

    // sector offset: red first, then green, then blue on ties
    priority if (mx == red_i) begin
      num = g_s - b_s;
      if (num < 0) num = num + $signed({1'b0, six_d});
    end else if (mx == green_i) begin
      num = (d_s <<< 1) + b_s - r_s;
    end else begin
      num = (d_s <<< 2) + r_s - g_s;
    end

    cell_d.valid = valid_i;
    if (dif == '0) begin
      // grey: 0 / 1 gives a zero hue
      cell_d.hue_rem = '0;
      cell_d.hue_div = rhsv_pkg::HueDivW'(1);
    end else begin
      cell_d.hue_rem = num[rhsv_pkg::HueDivW-1:0];
      cell_d.hue_div = six_d;
    end
    cell_d.hue_quo = '0;
    cell_d.sat_num = {dif, {rhsv_pkg::ChanW{1'b0}}} - {{rhsv_pkg::ChanW{1'b0}}, dif};
    cell_d.sat_rem = '0;
    cell_d.sat_div = (mx == '0) ? rhsv_pkg::ChanW'(1) : mx;
    cell_d.sat_quo = '0;
    cell_d.value   = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: src/rhsv_cell.sv
// rhsv_cell: one restoring-division step for hue and saturation, registered.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rhsv_pkg::cell_t cell_i,
  output rhsv_pkg::cell_t cell_o
);

  logic [rhsv_pkg::HueDivW:0] hue_two;
  logic [rhsv_pkg::HueDivW:0] hue_sub;
  logic                       hue_ge;
  logic [rhsv_pkg::ChanW:0]   sat_two;
  logic [rhsv_pkg::ChanW:0]   sat_sub;
  logic                       sat_ge;
  rhsv_pkg::cell_t            cell_d, cell_q;

  always_comb begin
    hue_two = {cell_i.hue_rem, 1'b0};
    hue_sub = hue_two - {1'b0, cell_i.hue_div};
    hue_ge  = hue_two >= {1'b0, cell_i.hue_div};
    sat_two = {cell_i.sat_rem, cell_i.sat_num[rhsv_pkg::SatNumW-1]};
    sat_sub = sat_two - {1'b0, cell_i.sat_div};
    sat_ge  = sat_two >= {1'b0, cell_i.sat_div};

    cell_d         = cell_i;
    cell_d.hue_rem = hue_ge ? hue_sub[rhsv_pkg::HueDivW-1:0] : hue_two[rhsv_pkg::HueDivW-1:0];
    cell_d.hue_quo = {cell_i.hue_quo[rhsv_pkg::HueW-2:0], hue_ge};
    cell_d.sat_num = {cell_i.sat_num[rhsv_pkg::SatNumW-2:0], 1'b0};
    cell_d.sat_rem = sat_ge ? sat_sub[rhsv_pkg::ChanW-1:0] : sat_two[rhsv_pkg::ChanW-1:0];
    cell_d.sat_quo = {cell_i.sat_quo[rhsv_pkg::ChanW-2:0], sat_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: src/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: top level, RGB to HSV pixel converter.
// Depends on rhsv_pkg, rhsv_prep and rhsv_cell.
`timescale 1ns / 1ps

// Takes one pixel request per clock, every clock: busy is always low, so a
// request is taken whenever start is high. Each result appears on hue_o,
// saturation_o and brightness_o for a single cycle with valid_o high, once
// it has passed the front-stage register and every cell register, in request order. The
// receiver cannot stall the block and must take every result when shown.
// The pipeline is the front stage (max/min and sector selection, one
// register) plus a row of 16 division cells, one quotient bit per cell for
// the 16-bit hue; the 8-bit saturation divider rides in the same cells.
// The block keeps no state across pixels; reset only empties the pipeline.

module rgb_to_hsv_pixel (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rhsv_pkg::ChanW-1:0] red_i,
  input  logic [rhsv_pkg::ChanW-1:0] green_i,
  input  logic [rhsv_pkg::ChanW-1:0] blue_i,
  output logic                       valid_o,
  output logic [rhsv_pkg::HueW-1:0]  hue_o,
  output logic [rhsv_pkg::ChanW-1:0] saturation_o,
  output logic [rhsv_pkg::ChanW-1:0] brightness_o
);

  localparam int unsigned Latency = rhsv_pkg::NumCells + 1;

  // stage[0] is the front stage, stage[k] the output of cell k
  rhsv_pkg::cell_t stage [rhsv_pkg::NumCells+1];

  // fully pipelined: never refuses a request
  assign busy = 1'b0;

  rhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .cell_o  (stage[0])
  );

  for (genvar i = 0; i < rhsv_pkg::NumCells; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (stage[i]),
      .cell_o (stage[i+1])
    );
  end

  // last cell's register is the output register
  assign valid_o      = stage[rhsv_pkg::NumCells].valid;
  assign hue_o        = stage[rhsv_pkg::NumCells].hue_quo;
  assign saturation_o = stage[rhsv_pkg::NumCells].sat_quo;
  assign brightness_o = stage[rhsv_pkg::NumCells].value;

  // a taken request comes out on valid_o at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency valid_o)
    else $error("result missing after request");

  // nothing comes out without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !valid_o)
    else $error("result without request");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with nonzero hue or saturation");

  // value is the largest channel of the matching request
  a_value_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (brightness_o >= $past(red_i, Latency) &&
                 brightness_o >= $past(green_i, Latency) &&
                 brightness_o >= $past(blue_i, Latency)))
    else $error("brightness below an input channel");

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for rgb_to_hsv_pixel, corner pixels then random streams.
// Depends on rhsv_pkg and rgb_to_hsv_pixel.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PipeDepth  = 17;       // request-to-result latency of the block
  localparam int unsigned CycleLimit = 200000;   // watchdog bound, generous for a correct run

  // One HSV result, laid out like the result ports.
  typedef struct packed {
    logic [rhsv_pkg::HueW-1:0]  hue;
    logic [rhsv_pkg::ChanW-1:0] sat;
    logic [rhsv_pkg::ChanW-1:0] val;
  } hsv_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [rhsv_pkg::ChanW-1:0] red_i;
  logic [rhsv_pkg::ChanW-1:0] green_i;
  logic [rhsv_pkg::ChanW-1:0] blue_i;
  logic                       valid_o;
  logic [rhsv_pkg::HueW-1:0]  hue_o;
  logic [rhsv_pkg::ChanW-1:0] saturation_o;
  logic [rhsv_pkg::ChanW-1:0] brightness_o;

  hsv_t        pending_hsv[$];   // predicted results, oldest first
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  rgb_to_hsv_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a hung pipeline or lost results end the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Pixel to HSV, exact integer math, truncation toward zero.
  // Sector goes to the first of red, green, blue that holds the max.
  function automatic hsv_t hsv_of(input logic [rhsv_pkg::ChanW-1:0] r,
                                  input logic [rhsv_pkg::ChanW-1:0] g,
                                  input logic [rhsv_pkg::ChanW-1:0] b);
    int   hi;
    int   lo;
    int   span;
    int   turn;
    hsv_t res;
    hi = int'(r);
    lo = int'(r);
    if (int'(g) > hi) hi = int'(g);
    if (int'(b) > hi) hi = int'(b);
    if (int'(g) < lo) lo = int'(g);
    if (int'(b) < lo) lo = int'(b);
    span = hi - lo;
    res = '0;
    res.val = hi[rhsv_pkg::ChanW-1:0];
    if (hi != 0) res.sat = rhsv_pkg::ChanW'((span * 255) / hi);   // black keeps saturation 0
    if (span != 0) begin                                        // grey keeps hue 0
      if (hi == int'(r)) begin
        turn = int'(g) - int'(b);
      end else if (hi == int'(g)) begin
        turn = 2 * span + int'(b) - int'(r);
      end else begin
        turn = 4 * span + int'(r) - int'(g);
      end
      // wrap into one turn, [0, 6*span)
      if (turn < 0) turn += 6 * span;
      if (turn >= 6 * span) turn -= 6 * span;
      res.hue = rhsv_pkg::HueW'((turn * 65536) / (6 * span));
    end
    return res;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && valid_o) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: result with no request pending: hue %0d sat %0d val %0d",
                 $time, hue_o, saturation_o, brightness_o);
        mismatch_count++;
      end else begin
        want = pending_hsv.pop_front();
        if (hue_o !== want.hue) begin
          $display("%0t: hue expected %0d, got %0d", $time, want.hue, hue_o);
          mismatch_count++;
        end
        if (saturation_o !== want.sat) begin
          $display("%0t: saturation expected %0d, got %0d", $time, want.sat, saturation_o);
          mismatch_count++;
        end
        if (brightness_o !== want.val) begin
          $display("%0t: brightness expected %0d, got %0d", $time, want.val, brightness_o);
          mismatch_count++;
        end
      end
    end
  end

  // Issue one pixel request. Idle cycles ahead of it put random junk on the
  // channels with start low. Start is left high on return so back-to-back
  // requests never drop it.
  task automatic send_pixel(input logic [rhsv_pkg::ChanW-1:0] r,
                            input logic [rhsv_pkg::ChanW-1:0] g,
                            input logic [rhsv_pkg::ChanW-1:0] b,
                            input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      red_i   <= rhsv_pkg::ChanW'($urandom);
      green_i <= rhsv_pkg::ChanW'($urandom);
      blue_i  <= rhsv_pkg::ChanW'($urandom);
      @(posedge clk_i);
    end
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    do @(posedge clk_i); while (busy);
    pending_hsv.push_back(hsv_of(r, g, b));
  endtask

  // Random pixel, biased toward greys, ties and channel extremes.
  task automatic pick_pixel(output logic [rhsv_pkg::ChanW-1:0] r,
                            output logic [rhsv_pkg::ChanW-1:0] g,
                            output logic [rhsv_pkg::ChanW-1:0] b);
    logic [rhsv_pkg::ChanW-1:0] ch[3];
    logic [rhsv_pkg::ChanW-1:0] tmp;
    int unsigned                hi;
    int unsigned                lo;
    int unsigned                j;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        foreach (ch[i]) ch[i] = rhsv_pkg::ChanW'($urandom);
      end
      4: begin                          // grey
        ch[0] = rhsv_pkg::ChanW'($urandom);
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      5: begin                          // two channels tied at the max
        hi = $urandom_range(255);
        lo = $urandom_range(hi);
        ch[0] = rhsv_pkg::ChanW'(hi);
        ch[1] = rhsv_pkg::ChanW'(hi);
        ch[2] = rhsv_pkg::ChanW'(lo);
      end
      6: begin                          // near black
        foreach (ch[i]) ch[i] = rhsv_pkg::ChanW'($urandom_range(3));
      end
      7: begin                          // rail values
        foreach (ch[i]) begin
          case ($urandom_range(3))
            0: ch[i] = 8'd0;
            1: ch[i] = 8'd1;
            2: ch[i] = 8'd254;
            default: ch[i] = 8'd255;
          endcase
        end
      end
      default: begin                    // ordered max/mid/min
        hi = $urandom_range(255);
        lo = $urandom_range(hi);
        ch[0] = rhsv_pkg::ChanW'(hi);
        ch[1] = rhsv_pkg::ChanW'($urandom_range(hi, lo));
        ch[2] = rhsv_pkg::ChanW'(lo);
      end
    endcase
    // shuffle so every channel gets every role
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = ch[i];
      ch[i] = ch[j];
      ch[j] = tmp;
    end
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    logic [rhsv_pkg::ChanW-1:0] r;
    logic [rhsv_pkg::ChanW-1:0] g;
    logic [rhsv_pkg::ChanW-1:0] b;
    repeat (count) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b, idle_pct);
    end
  endtask

  // Black, white, primaries, tie-breaks, hue wrap near a full turn.
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0,   0);   // black
    send_pixel(8'd255, 8'd255, 8'd255, 0);   // white
    send_pixel(8'd128, 8'd128, 8'd128, 0);   // mid grey
    send_pixel(8'd1,   8'd1,   8'd1,   0);
    send_pixel(8'd255, 8'd0,   8'd0,   0);   // red
    send_pixel(8'd0,   8'd255, 8'd0,   0);   // green
    send_pixel(8'd0,   8'd0,   8'd255, 0);   // blue
    send_pixel(8'd255, 8'd255, 8'd0,   0);   // red/green tie, red wins
    send_pixel(8'd0,   8'd255, 8'd255, 0);   // green/blue tie, green wins
    send_pixel(8'd255, 8'd0,   8'd255, 0);   // red/blue tie, negative offset wraps
    send_pixel(8'd255, 8'd0,   8'd1,   0);   // hue just under a full turn
    send_pixel(8'd255, 8'd1,   8'd0,   0);
    send_pixel(8'd1,   8'd0,   8'd0,   0);   // smallest nonzero span
    send_pixel(8'd0,   8'd0,   8'd1,   0);
    send_pixel(8'd0,   8'd1,   8'd0,   0);
    send_pixel(8'd255, 8'd254, 8'd254, 0);   // low saturation
    send_pixel(8'd254, 8'd255, 8'd253, 0);
    send_pixel(8'd1,   8'd0,   8'd255, 0);
    send_pixel(8'd0,   8'd255, 8'd1,   0);
    send_pixel(8'd170, 8'd85,  8'd255, 0);
    send_pixel(8'd255, 8'd128, 8'd0,   0);
  endtask

  // Full rate: a request every clock.
  task automatic test_full_rate_stream();
    run_random(600, 0);
  endtask

  // Sparse source: before each request, another idle gap is drawn with 65 percent odds.
  task automatic test_sparse_stream();
    run_random(620, 65);
  endtask

  // Sink-side stalls don't exist here (no ready), so this phase only mixes
  // in moderate source gaps.
  task automatic test_mixed_gaps_stream();
    run_random(610, 38);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    red_i   = '0;
    green_i = '0;
    blue_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_full_rate_stream();
    test_sparse_stream();
    test_mixed_gaps_stream();

    start <= 1'b0;
    // drain, then give the pipe time to show any stray strobe
    while (pending_hsv.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
src/rhsv_pkg.sv
src/rhsv_prep.sv
src/rhsv_cell.sv
src/rgb_to_hsv_pixel.sv
bench/testbench.sv
